// File: rtl/tvsc_pkg.sv
// ----------------------------------------------------------------------------
// Typed value converter package
// Type codes, queue entry layout and shared constants.
// ----------------------------------------------------------------------------
package tvsc_pkg;

    typedef enum logic [2:0] {
        KIND_BOOL = 3'd0,
        KIND_F32  = 3'd1,
        KIND_U8   = 3'd2,
        KIND_U16  = 3'd3,
        KIND_U32  = 3'd4,
        KIND_I16  = 3'd5,
        KIND_I32  = 3'd6,
        KIND_BAD  = 3'd7
    } kind_t;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [31:0] fval;      // source as float32
        logic [31:0] raw;       // source bits masked to the destination type width
        logic        same;      // source and destination types match
        logic        bad;       // invalid destination type
        kind_t       dest;
    } entry_t;

endpackage

// File: rtl/tvsc_front.sv
// ----------------------------------------------------------------------------
// Converter front end
// Classifies an item and turns its source value into float32, round to even.
// ----------------------------------------------------------------------------
module tvsc_front
    import tvsc_pkg::*;
(
    input  logic [31:0] source_bits,
    input  logic [2:0]  source_kind,
    input  logic [2:0]  dest_kind,
    output entry_t      entry
);

    logic        sg;
    logic [31:0] mag;
    logic [4:0]  pos;
    logic [31:0] norm;
    logic [24:0] mant;
    logic        rnd;
    logic [7:0]  expo;
    logic [31:0] conv;
    logic [31:0] masked;

    always_comb
    begin
        sg  = 1'b0;
        mag = 32'd0;
        case (kind_t'(source_kind))
            KIND_BOOL: mag = {31'd0, source_bits[0]};
            KIND_U8:   mag = {24'd0, source_bits[7:0]};
            KIND_U16:  mag = {16'd0, source_bits[15:0]};
            KIND_U32:  mag = source_bits;
            KIND_I16:
            begin
                sg  = source_bits[15];
                mag = sg ? (32'h10000 - {16'd0, source_bits[15:0]})
                         : {16'd0, source_bits[15:0]};
            end
            KIND_I32:
            begin
                sg  = source_bits[31];
                mag = sg ? (32'd0 - source_bits) : source_bits;
            end
            default: mag = 32'd0;
        endcase

        pos = 5'd0;
        for (int i = 0; i < 32; i++)
        begin
            if (mag[i])
            begin
                pos = 5'(i);
            end
        end

        // The leading one lands in bit 31; bits below the 24 kept ones round.
        norm = mag << (5'd31 - pos);
        rnd  = norm[7] & ((|norm[6:0]) | norm[8]);
        mant = {1'b0, norm[31:8]} + {24'd0, rnd};
        expo = 8'd127 + {3'd0, pos} + {7'd0, mant[24]};

        if (mag == 32'd0)
        begin
            conv = 32'd0;
        end
        else
        begin
            conv = {sg, expo, mant[24] ? 23'd0 : mant[22:0]};
        end

        case (kind_t'(source_kind))
            KIND_F32: conv = source_bits;
            default:  ;
        endcase

        case (kind_t'(dest_kind))
            KIND_BOOL:          masked = {31'd0, source_bits[0]};
            KIND_U8:            masked = {24'd0, source_bits[7:0]};
            KIND_U16, KIND_I16: masked = {16'd0, source_bits[15:0]};
            default:            masked = source_bits;
        endcase

        entry.fval = conv;
        entry.raw  = masked;
        entry.same = (source_kind == dest_kind);
        entry.bad  = (kind_t'(dest_kind) == KIND_BAD);
        entry.dest = kind_t'(dest_kind);
    end

endmodule

// File: rtl/tvsc_queue.sv
// ----------------------------------------------------------------------------
// Converter queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module tvsc_queue
    import tvsc_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_data,
    input  logic   pop,
    output entry_t pop_data,
    output logic   empty,
    output logic   full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    entry_t          mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign empty    = (count_reg == CW'(0));
    assign full     = (count_reg == CW'(DEPTH));
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : wr_ptr_reg + AW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? AW'(0) : rd_ptr_reg + AW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: rtl/tvsc_back.sv
// ----------------------------------------------------------------------------
// Converter back end
// Rounds half away from zero, saturates to the destination and registers it.
// ----------------------------------------------------------------------------
module tvsc_back
    import tvsc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        valid,
    input  entry_t      entry,
    output logic [31:0] dest_bits,
    output logic        bad_type,
    output logic        done
);

    logic [31:0] bits_reg, bits_next;
    logic        bad_reg, bad_next;
    logic        done_reg;

    logic        sg;
    logic [7:0]  ex;
    logic        is_nan;
    logic        huge;
    logic [31:0] full;
    logic [31:0] mag;
    logic [4:0]  sh;
    logic [31:0] half_bits;
    logic [31:0] neg;

    always_comb
    begin
        sg     = entry.fval[31];
        ex     = entry.fval[30:23];
        is_nan = (ex == 8'hFF) && (entry.fval[22:0] != 23'd0);
        huge   = (ex >= 8'd159);
        full   = {8'd0, 1'b1, entry.fval[22:0]};
        sh     = 5'd0;
        half_bits = 32'd0;
        if (ex < 8'd126)
        begin
            mag = 32'd0;
        end
        else if (ex >= 8'd150)
        begin
            mag = full << 5'(ex - 8'd150);
        end
        else
        begin
            // Below 2^23 the dropped fraction is rounded up from one half.
            sh        = 5'(8'd150 - ex);
            half_bits = full >> (sh - 5'd1);
            mag       = (full >> sh) + {31'd0, half_bits[0]};
        end
        neg = 32'd0 - mag;

        bits_next = 32'd0;
        bad_next  = entry.bad;
        if (entry.bad)
        begin
            bits_next = 32'd0;
        end
        else if (entry.same)
        begin
            bits_next = entry.raw;
        end
        else
        begin
            case (entry.dest)
                KIND_BOOL: bits_next = {31'd0, |entry.fval[30:0]};
                KIND_F32:  bits_next = entry.fval;
                KIND_U8:
                begin
                    if (is_nan || sg)
                        bits_next = 32'd0;
                    else if (huge || mag > 32'd255)
                        bits_next = 32'd255;
                    else
                        bits_next = mag;
                end
                KIND_U16:
                begin
                    if (is_nan || sg)
                        bits_next = 32'd0;
                    else if (huge || mag > 32'd65535)
                        bits_next = 32'd65535;
                    else
                        bits_next = mag;
                end
                KIND_U32:
                begin
                    if (is_nan || sg)
                        bits_next = 32'd0;
                    else if (huge)
                        bits_next = 32'hFFFF_FFFF;
                    else
                        bits_next = mag;
                end
                KIND_I16:
                begin
                    if (is_nan)
                        bits_next = 32'd0;
                    else if (sg)
                        bits_next = (huge || mag >= 32'd32768) ? 32'h0000_8000
                                                                : {16'd0, neg[15:0]};
                    else
                        bits_next = (huge || mag > 32'd32767) ? 32'h0000_7FFF : mag;
                end
                KIND_I32:
                begin
                    if (is_nan)
                        bits_next = 32'd0;
                    else if (sg)
                        bits_next = (huge || mag[31]) ? 32'h8000_0000 : neg;
                    else
                        bits_next = (huge || mag[31]) ? 32'h7FFF_FFFF : mag;
                end
                default: bits_next = 32'd0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (valid)
        begin
            bits_reg <= bits_next;
            bad_reg  <= bad_next;
        end
    end

    assign dest_bits = bits_reg;
    assign bad_type  = bad_reg;
    assign done      = done_reg;

endmodule

// File: rtl/typed_value_saturating_convert_core.sv
// ----------------------------------------------------------------------------
// Typed value saturating converter
// Stores a value of one numeric type into another, with rounding and clamping.
// ----------------------------------------------------------------------------
// An item (source_bits, source_kind, dest_kind) is taken at a rising edge with
// start high and busy low. The front end classifies it and converts the
// source to float32; the item then waits in a short queue. The back end
// takes one entry per cycle, rounds half away from zero, saturates to the
// destination type and registers the outcome.
// The result appears on dest_bits and bad_type after the queue write and the
// output register of the back end, marked by done for exactly one cycle; the
// receiver cannot hold it off. One item is taken every cycle while busy is low.
// busy rises only if the queue fills, which it does not while the back end
// drains an entry every cycle.
// Reset empties the queue and clears done; no result is pending after it.
// ----------------------------------------------------------------------------
module typed_value_saturating_convert_core
    import tvsc_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] source_bits,
    input  logic [2:0]  source_kind,
    input  logic [2:0]  dest_kind,
    output logic        done,
    output logic [31:0] dest_bits,
    output logic        bad_type
);

    entry_t front_entry;
    entry_t back_entry;
    logic   q_empty;
    logic   q_full;
    logic   push;
    logic   pop;

    assign busy = q_full;
    assign push = start && !q_full;
    assign pop  = !q_empty;

    tvsc_front u_front (
        .source_bits (source_bits),
        .source_kind (source_kind),
        .dest_kind   (dest_kind),
        .entry       (front_entry)
    );

    tvsc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (front_entry),
        .pop       (pop),
        .pop_data  (back_entry),
        .empty     (q_empty),
        .full      (q_full)
    );

    tvsc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid     (pop),
        .entry     (back_entry),
        .dest_bits (dest_bits),
        .bad_type  (bad_type),
        .done      (done)
    );

endmodule

// File: verif/typed_value_saturating_convert_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Typed value saturating converter testbench
// Sends typed values through the converter, with directed corner cases
// followed by random traffic and random idle bursts. Each result is checked
// against a bit-level model of the conversion, rounding and clamping.
// ----------------------------------------------------------------------------
module typed_value_saturating_convert_core_tb;
    import tvsc_pkg::*;

    typedef struct {
        logic [31:0] bits;
        logic        bad;
    } conv_result_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [31:0] source_bits;
    logic [2:0]  source_kind;
    logic [2:0]  dest_kind;
    logic        done;
    logic [31:0] dest_bits;
    logic        bad_type;

    conv_result_t expected_q[$];
    int           fail_count;
    bit           idle_enable;

    typed_value_saturating_convert_core DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .source_bits (source_bits),
        .source_kind (source_kind),
        .dest_kind   (dest_kind),
        .done        (done),
        .dest_bits   (dest_bits),
        .bad_type    (bad_type)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Integer magnitude to float32 with round to nearest even.
    function automatic logic [31:0] int_to_float(bit neg, logic [31:0] mag);
        int          p;
        int          s;
        logic [31:0] keep;
        logic [31:0] rem;
        logic [31:0] half;
        logic [31:0] frac;
        if (mag == 32'd0)
            return 32'd0;
        p = 31;
        while (!mag[p])
            p--;
        if (p <= 23)
        begin
            frac = mag << (23 - p);
        end
        else
        begin
            s    = p - 23;
            keep = mag >> s;
            rem  = mag & ((32'd1 << s) - 32'd1);
            half = 32'd1 << (s - 1);
            if (rem > half || (rem == half && keep[0]))
                keep++;
            if (keep[24])
            begin
                keep = keep >> 1;
                p++;
            end
            frac = keep;
        end
        return {neg, 8'(p + 127), frac[22:0]};
    endfunction

    function automatic logic [31:0] source_as_float(logic [31:0] bits, kind_t kind);
        case (kind)
            KIND_BOOL: return bits[0] ? 32'h3F80_0000 : 32'd0;
            KIND_F32:  return bits;
            KIND_U8:   return int_to_float(1'b0, {24'd0, bits[7:0]});
            KIND_U16:  return int_to_float(1'b0, {16'd0, bits[15:0]});
            KIND_U32:  return int_to_float(1'b0, bits);
            KIND_I16:
                if (bits[15])
                    return int_to_float(1'b1, 32'h1_0000 - {16'd0, bits[15:0]});
                else
                    return int_to_float(1'b0, {16'd0, bits[15:0]});
            KIND_I32:
                if (bits[31])
                    return int_to_float(1'b1, 32'd0 - bits);
                else
                    return int_to_float(1'b0, bits);
            default:   return 32'd0;
        endcase
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    function automatic conv_result_t convert_value(logic [31:0] bits, kind_t src, kind_t dst);
        conv_result_t r;
        logic [31:0]  f;
        logic [7:0]   e;
        logic [23:0]  m;
        longint       mag;
        longint       v;
        int           sh;
        r.bits = 32'd0;
        r.bad  = 1'b0;
        if (dst == KIND_BAD)
        begin
            r.bad = 1'b1;
            return r;
        end
        if (src == dst)
        begin
            case (dst)
                KIND_BOOL:         r.bits = {31'd0, bits[0]};
                KIND_U8:           r.bits = {24'd0, bits[7:0]};
                KIND_U16, KIND_I16: r.bits = {16'd0, bits[15:0]};
                default:           r.bits = bits;
            endcase
            return r;
        end
        f = source_as_float(bits, src);
        if (dst == KIND_BOOL)
        begin
            r.bits = {31'd0, f[30:0] != 31'd0};
            return r;
        end
        if (dst == KIND_F32)
        begin
            r.bits = f;
            return r;
        end
        e = f[30:23];
        m = {1'b1, f[22:0]};
        if (e == 8'hFF && f[22:0] != 23'd0)
            return r;                         // NaN converts to zero
        // Rounded magnitude, half away from zero; anything huge is capped.
        if (e == 8'hFF || e > 8'd166)
            mag = longint'(1) << 40;
        else if (e >= 8'd150)
            mag = longint'(m) << (e - 150);
        else if (e < 8'd126)
            mag = 0;
        else
        begin
            sh  = 150 - e;
            mag = longint'(m >> sh) + longint'((m >> (sh - 1)) & 24'd1);
        end
        v = f[31] ? -mag : mag;
        case (dst)
            KIND_U8:  r.bits = 32'(clamp(v, 0, 255));
            KIND_U16: r.bits = 32'(clamp(v, 0, 65535));
            KIND_U32: r.bits = 32'(clamp(v, 0, 64'h0000_0000_FFFF_FFFF));
            KIND_I16: r.bits = {16'd0, 16'(clamp(v, -32768, 32767))};
            default:  r.bits = 32'(clamp(v, -64'sd2147483648, 64'sd2147483647));
        endcase
        return r;
    endfunction

    // Result checker: every strobed result is matched with the oldest expectation.
    always @(posedge clk)
    begin
        conv_result_t exp_r;
        if (rst_n && done)
        begin
            if (expected_q.size() == 0)
            begin
                $error("result with no expectation: dest_bits %h bad_type %b",
                       dest_bits, bad_type);
                fail_count++;
            end
            else
            begin
                exp_r = expected_q.pop_front();
                if (dest_bits !== exp_r.bits)
                begin
                    $error("dest_bits: expected %h, actual %h", exp_r.bits, dest_bits);
                    fail_count++;
                end
                if (bad_type !== exp_r.bad)
                begin
                    $error("bad_type: expected %b, actual %b", exp_r.bad, bad_type);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_value(logic [31:0] bits, kind_t src, kind_t dst);
        start       <= 1'b1;
        source_bits <= bits;
        source_kind <= src;
        dest_kind   <= dst;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_q.push_back(convert_value(bits, src, dst));
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic kind_t rand_kind(bit allow_bad);
        return kind_t'($urandom_range(0, allow_bad ? 7 : 6));
    endfunction

    // Float with exponent near the integer ranges, often on an exact half.
    function automatic logic [31:0] rand_float();
        logic [31:0] f;
        int          e;
        int          sh;
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return {$urandom_range(0, 1) == 1, 8'hFF,
                       ($urandom_range(0, 1) == 1) ? 23'($urandom()) : 23'd0};
            2: return {$urandom_range(0, 1) == 1, 31'd0};
            default:
            begin
                e = $urandom_range(120, 165);
                f = {$urandom_range(0, 1) == 1, 8'(e), 23'($urandom())};
                if (e >= 127 && e <= 149 && $urandom_range(0, 1) == 1)
                begin
                    sh = 150 - e;
                    f[sh - 1] = 1'b1;
                    f = f & ~((32'd1 << (sh - 1)) - 32'd1);
                end
                return f;
            end
        endcase
    endfunction

    task automatic test_directed();
        send_value(32'h0000_0003, KIND_BOOL, KIND_BOOL);
        send_value(32'hFFFF_FFFE, KIND_BOOL, KIND_I32);
        send_value(32'hDEAD_BEEF, KIND_U8, KIND_U8);
        send_value(32'hDEAD_BEEF, KIND_I16, KIND_I16);
        send_value(32'h7FC0_1234, KIND_F32, KIND_F32);
        send_value(32'h1234_5678, KIND_I32, KIND_BAD);
        send_value(32'h3F80_0000, KIND_F32, KIND_BAD);
        send_value(32'h7FC0_0000, KIND_F32, KIND_I32);
        send_value(32'hFFC0_0000, KIND_F32, KIND_BOOL);
        send_value(32'h8000_0000, KIND_F32, KIND_BOOL);
        send_value(32'h7F80_0000, KIND_F32, KIND_U32);
        send_value(32'hFF80_0000, KIND_F32, KIND_I32);
        send_value(32'h3F00_0000, KIND_F32, KIND_U8);
        send_value(32'hBFC0_0000, KIND_F32, KIND_I16);
        send_value(32'h4040_0000 | 32'h0020_0000, KIND_F32, KIND_I16);
        send_value(32'h437F_8000, KIND_F32, KIND_U8);
        send_value(32'h4F00_0000, KIND_F32, KIND_I32);
        send_value(32'hCF00_0000, KIND_F32, KIND_I32);
        send_value(32'hFFFF_FFFF, KIND_U32, KIND_F32);
        send_value(32'h0100_0001, KIND_U32, KIND_I32);
        send_value(32'h8000_0000, KIND_I32, KIND_I16);
        send_value(32'h0000_8000, KIND_I16, KIND_U32);
        send_value(32'h0000_FFFF, KIND_U16, KIND_I16);
        send_value(32'hFFFF_FFFF, KIND_BAD, KIND_U16);
        send_value(32'h0000_0000, KIND_BAD, KIND_BAD);
    endtask

    task automatic test_random_mixed(int count);
        repeat (count) send_value($urandom(), rand_kind(1), rand_kind(1));
    endtask

    task automatic test_random_float_source(int count);
        repeat (count) send_value(rand_float(), KIND_F32, rand_kind(0));
    endtask

    task automatic test_random_integer_source(int count);
        logic [31:0] bits;
        repeat (count)
        begin
            bits = $urandom();
            if ($urandom_range(0, 2) == 0)
                bits = bits >> $urandom_range(0, 31);
            send_value(bits, kind_t'($urandom_range(2, 6)), rand_kind(0));
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        source_bits = 32'd0;
        source_kind = KIND_BOOL;
        dest_kind   = KIND_BOOL;
        fail_count  = 0;
        idle_enable = 1'b1;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        wait_drained();
        test_random_mixed(300);
        test_random_float_source(300);
        wait_drained();
        test_random_integer_source(250);
        // The last stretch runs back to back with no idle cycles.
        idle_enable = 1'b0;
        test_random_mixed(175);
        start <= 1'b0;
        @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Mismatches found");
        $finish;
    end

endmodule

// File: files.f
rtl/tvsc_pkg.sv
rtl/tvsc_front.sv
rtl/tvsc_queue.sv
rtl/tvsc_back.sv
rtl/typed_value_saturating_convert_core.sv
verif/typed_value_saturating_convert_core_tb.sv
